/* hdl/setm_pkg.sv */
// ----------------------------------------------------------------------------
// SPI EEPROM transaction master package
// Shared item types, command and status codes, and pin-step descriptors.
// ----------------------------------------------------------------------------
package setm_pkg;

  localparam int BUF_DEPTH_DEF  = 32;
  localparam int FIFO_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_DONE   = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_INSTR = 5'b00010,
    PH_ADDR  = 5'b00100,
    PH_WRITE = 5'b01000,
    PH_READ  = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    K_SINGLE = 2'd0,
    K_START  = 2'd1,
    K_TICK   = 2'd2,
    K_CLOSE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  index;
    logic [7:0]  data_byte;
    logic [7:0]  instr;
    logic        addr_en;
    logic [15:0] addr;
    logic [5:0]  wr_len;
    logic [5:0]  rd_len;
    logic        close;
    logic        miso;
  } in_item_t;

  typedef struct packed {
    logic       mosi;
    logic       sclk;
    logic       cs_n;
    logic [7:0] read_data;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // pins are {mosi, sclk, cs_n}
  typedef struct packed {
    kind_t      kind;
    logic [2:0] pins;
    logic       d;
    logic [7:0] rd;
    logic [1:0] st;
  } desc_t;

endpackage

/* hdl/setm_front.sv */
// ----------------------------------------------------------------------------
// SPI EEPROM transaction front end
// Accepts requests, runs the transaction sequencer and the buffers, and
// queues one pin-step descriptor per request.
// ----------------------------------------------------------------------------
module setm_front import setm_pkg::*; #(
  parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int LW         = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  input  logic [LW-1:0] fifo_level,
  output logic          push,
  output desc_t         push_desc
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [5:0]  byte_r, byte_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        addr_en_r, addr_en_nxt;
  logic        close_r, close_nxt;
  logic [5:0]  wcnt_r, wcnt_nxt;
  logic [5:0]  rcnt_r, rcnt_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [2:0]  pins_r, pins_nxt;
  logic        tx_pend_r, tx_pend_nxt;
  logic        b_valid_r;
  desc_t       b_desc_r, desc_nxt;
  logic        b_isrd_r, isrd_nxt;

  logic [7:0]  tx_mem [BUF_DEPTH];
  logic [7:0]  rx_mem [BUF_DEPTH];
  logic [7:0]  tx_rdata_r;
  logic [7:0]  rx_rdata_r;

  logic          accept;
  logic          idx_ok;
  logic [15:0]   shift_eff;
  logic [7:0]    rx_shift;
  logic [4:0]    bit_dec;
  logic [5:0]    byte_inc;
  logic [5:0]    wb;
  logic [5:0]    rb;
  logic          d_bit;
  logic          tx_wr_en;
  logic          tx_rd_en;
  logic [AW-1:0] tx_rd_addr;
  logic          rx_wr_en;
  logic          rx_rd_en;

  assign in_stall  = (32'(fifo_level) + 32'(b_valid_r)) >= FIFO_DEPTH;
  assign accept    = in_valid && !in_stall;
  assign idx_ok    = 32'(in_data.index) < BUF_DEPTH;
  assign shift_eff = tx_pend_r ? {tx_rdata_r, 8'h00} : shift_r;
  assign rx_shift  = {rx_r[6:0], in_data.miso};
  assign bit_dec   = bit_r - 5'd1;
  assign byte_inc  = byte_r + 6'd1;
  assign wb        = (phase_r == PH_WRITE) ? byte_inc : 6'd0;
  assign rb        = (phase_r == PH_READ) ? byte_inc : 6'd0;
  assign d_bit     = (phase_r == PH_READ) ? 1'b0 : shift_eff[15];

  always_comb begin
    phase_nxt     = phase_r;
    bit_nxt       = bit_r;
    byte_nxt      = byte_r;
    shift_nxt     = shift_eff;
    rx_nxt        = rx_r;
    addr_en_nxt   = addr_en_r;
    close_nxt     = close_r;
    wcnt_nxt      = wcnt_r;
    rcnt_nxt      = rcnt_r;
    addr_nxt      = addr_r;
    pins_nxt      = pins_r;
    tx_pend_nxt   = 1'b0;
    tx_wr_en      = 1'b0;
    tx_rd_en      = 1'b0;
    tx_rd_addr    = AW'(wb);
    rx_wr_en      = 1'b0;
    rx_rd_en      = 1'b0;
    isrd_nxt      = 1'b0;
    desc_nxt.kind = K_SINGLE;
    desc_nxt.pins = pins_r;
    desc_nxt.d    = 1'b0;
    desc_nxt.rd   = 8'h00;
    desc_nxt.st   = ST_OK;
    if (accept) begin
      case (in_data.cmd)
        CMD_LOAD: begin
          tx_wr_en = idx_ok;
        end
        CMD_READ: begin
          rx_rd_en = 1'b1;
          isrd_nxt = idx_ok;
        end
        CMD_START: begin
          if (phase_r != PH_IDLE) begin
            desc_nxt.st = ST_REJECT;
          end else begin
            phase_nxt     = PH_INSTR;
            bit_nxt       = 5'd8;
            byte_nxt      = 6'd0;
            rx_nxt        = 8'h00;
            shift_nxt     = {in_data.instr, 8'h00};
            addr_en_nxt   = in_data.addr_en;
            close_nxt     = in_data.close;
            addr_nxt      = in_data.addr;
            wcnt_nxt      = (32'(in_data.wr_len) > BUF_DEPTH) ?
                            6'(BUF_DEPTH) : in_data.wr_len;
            rcnt_nxt      = (32'(in_data.rd_len) > BUF_DEPTH) ?
                            6'(BUF_DEPTH) : in_data.rd_len;
            pins_nxt      = 3'b010;
            desc_nxt.kind = K_START;
          end
        end
        CMD_TICK: begin
          if (phase_r == PH_IDLE) begin
            desc_nxt.st = ST_REJECT;
          end else begin
            desc_nxt.kind = K_TICK;
            desc_nxt.d    = d_bit;
            pins_nxt      = {d_bit, 2'b10};
            bit_nxt       = bit_dec;
            if (phase_r != PH_READ) begin
              shift_nxt = {shift_eff[14:0], 1'b0};
            end else begin
              rx_nxt = rx_shift;
            end
            if (bit_dec == 5'd0) begin
              rx_wr_en = (phase_r == PH_READ);
              if (phase_r == PH_INSTR && addr_en_r) begin
                phase_nxt = PH_ADDR;
                shift_nxt = addr_r;
                bit_nxt   = 5'd16;
              end else if (phase_r != PH_READ && wb < wcnt_r) begin
                phase_nxt   = PH_WRITE;
                byte_nxt    = wb;
                bit_nxt     = 5'd8;
                tx_rd_en    = 1'b1;
                tx_pend_nxt = 1'b1;
              end else if (rb < rcnt_r) begin
                phase_nxt = PH_READ;
                byte_nxt  = rb;
                bit_nxt   = 5'd8;
                rx_nxt    = 8'h00;
              end else begin
                phase_nxt   = PH_IDLE;
                byte_nxt    = rb;
                bit_nxt     = 5'd0;
                desc_nxt.st = ST_DONE;
                if (close_r) begin
                  desc_nxt.kind = K_CLOSE;
                  pins_nxt      = 3'b111;
                end
              end
            end
          end
        end
        default: begin
          desc_nxt.kind = K_SINGLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_r       <= 5'd0;
      byte_r      <= 6'd0;
      shift_r     <= 16'h0000;
      rx_r        <= 8'h00;
      addr_en_r   <= 1'b0;
      close_r     <= 1'b0;
      wcnt_r      <= 6'd0;
      rcnt_r      <= 6'd0;
      addr_r      <= 16'h0000;
      pins_r      <= 3'b111;
      tx_pend_r   <= 1'b0;
      b_valid_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      byte_r      <= byte_nxt;
      shift_r     <= shift_nxt;
      rx_r        <= rx_nxt;
      addr_en_r   <= addr_en_nxt;
      close_r     <= close_nxt;
      wcnt_r      <= wcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      addr_r      <= addr_nxt;
      pins_r      <= pins_nxt;
      tx_pend_r   <= tx_pend_nxt;
      b_valid_r   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    b_desc_r <= desc_nxt;
    b_isrd_r <= isrd_nxt;
  end

  always_ff @(posedge clk) begin
    if (tx_wr_en) begin
      tx_mem[AW'(in_data.index)] <= in_data.data_byte;
    end
    if (tx_rd_en) begin
      tx_rdata_r <= tx_mem[tx_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_wr_en) begin
      rx_mem[AW'(byte_r)] <= rx_shift;
    end
    if (rx_rd_en) begin
      rx_rdata_r <= rx_mem[AW'(in_data.index)];
    end
  end

  always_comb begin
    push_desc = b_desc_r;
    if (b_isrd_r) begin
      push_desc.rd = rx_rdata_r;
    end
  end

  assign push = b_valid_r;

endmodule

/* hdl/setm_fifo.sv */
// ----------------------------------------------------------------------------
// SPI EEPROM descriptor queue
// Short queue of pin-step descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module setm_fifo import setm_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int LW         = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  desc_t         push_desc,
  input  logic          pop,
  output desc_t         head,
  output logic [LW-1:0] level
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  desc_t         q_r [FIFO_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (32'(wr_r) == FIFO_DEPTH - 1) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (32'(rd_r) == FIFO_DEPTH - 1) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + LW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_desc;
    end
  end

  assign head  = q_r[rd_r];
  assign level = cnt_r;

endmodule

/* hdl/setm_back.sv */
// ----------------------------------------------------------------------------
// SPI EEPROM pin-step back end
// Expands each descriptor into its pin steps, one result per cycle unless out_stall holds it.
// ----------------------------------------------------------------------------
module setm_back import setm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  desc_t     head,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [1:0] beat_r, beat_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_r;
  out_item_t  step;
  logic [1:0] last_beat;
  logic       is_last;
  logic       load;

  always_comb begin
    case (head.kind)
      K_SINGLE: last_beat = 2'd0;
      K_START:  last_beat = 2'd1;
      K_TICK:   last_beat = 2'd1;
      K_CLOSE:  last_beat = 2'd3;
      default:  last_beat = 2'd0;
    endcase
  end

  assign is_last = (beat_r == last_beat);
  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign pop     = load && is_last;

  always_comb begin
    step.read_data = 8'h00;
    step.status    = is_last ? head.st : ST_OK;
    step.last      = is_last;
    {step.mosi, step.sclk, step.cs_n} = head.pins;
    case (head.kind)
      K_SINGLE: begin
        step.read_data = head.rd;
      end
      K_START: begin
        {step.mosi, step.sclk, step.cs_n} = (beat_r == 2'd0) ? 3'b111 : 3'b010;
      end
      K_TICK, K_CLOSE: begin
        case (beat_r)
          2'd0:    {step.mosi, step.sclk, step.cs_n} = {head.d, 2'b00};
          2'd1:    {step.mosi, step.sclk, step.cs_n} = {head.d, 2'b10};
          2'd2:    {step.mosi, step.sclk, step.cs_n} = 3'b010;
          default: {step.mosi, step.sclk, step.cs_n} = 3'b111;
        endcase
      end
      default: begin
        step.read_data = 8'h00;
      end
    endcase
  end

  always_comb begin
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      beat_nxt      = is_last ? 2'd0 : beat_r + 2'd1;
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= step;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hdl/spi_eeprom_transaction_master.sv */
// ----------------------------------------------------------------------------
// SPI EEPROM transaction master
// Runs one mode 3 EEPROM transaction, one serial bit per tick request:
// instruction, optional address, write bytes, then read bytes.
//
// Input channel (in_valid/in_stall/in_data) takes load, start, tick and read
// requests. Output channel (out_valid/out_stall/out_data) returns one result
// per pin step: load, read, rejected start or idle tick give one result,
// start and tick give two, a tick that closes the transaction gives four.
// The last result of each request has last set.
// Throughput: one result per cycle while out_stall is low; the output
// stage sets that rate. A request is taken every cycle while the
// descriptor queue has room.
// Reset: pins read high, the sequencer is idle, the buffers hold nothing
// valid until written. No clearing pass.
// A stalled receiver holds the output register; the queue fills and then
// in_stall rises until it drains.
// ----------------------------------------------------------------------------
module spi_eeprom_transaction_master import setm_pkg::*; #(
  parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int LW = $clog2(FIFO_DEPTH + 1);

  logic          push;
  desc_t         push_desc;
  logic          pop;
  desc_t         head;
  logic [LW-1:0] level;

  setm_front #(
    .BUF_DEPTH  (BUF_DEPTH),
    .FIFO_DEPTH (FIFO_DEPTH),
    .LW         (LW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .fifo_level (level),
    .push       (push),
    .push_desc  (push_desc)
  );

  setm_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .LW         (LW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .level     (level)
  );

  setm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (level != '0),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
